@@ rtl/core/cfla_pkg.sv @@
// Shared types and constants for the coalescing free-list allocator.
// No dependencies; referenced by the interfaces and imported by cfla_seq and the top level.
package cfla_pkg;

  localparam int STATUS_W = 3;
  localparam int ADDR_W   = 13;
  localparam int REQ_W    = 16;
  localparam int DIV_W    = 17;

  localparam logic FUNC_ALLOC = 1'b0;
  localparam logic FUNC_FREE  = 1'b1;

  typedef enum logic [2:0] {
    ST_OK      = 3'd0,
    ST_ZERO    = 3'd1,
    ST_NOMEM   = 3'd2,
    ST_BADFREE = 3'd3,
    ST_BADSIZE = 3'd4
  } status_t;

  typedef enum logic {
    CALL_FREE,
    CALL_GROW
  } caller_t;

  typedef enum logic [4:0] {
    S_IDLE,
    S_DIV,
    S_A_NX,
    S_A_P,
    S_A_RD,
    S_A_EV,
    S_A_SPLIT,
    S_G_CHK,
    S_G_OLD,
    S_G_NX,
    S_G_AD,
    S_F_RD,
    S_F_EV,
    S_I_RD,
    S_I_EV,
    S_I_F1,
    S_I_F2,
    S_I_F3,
    S_I_F4,
    S_DONE
  } state_t;

endpackage

@@ rtl/core/cfla_req_if.sv @@
// Request channel: allocate or free, valid/ready handshake.
// Depends on cfla_pkg.
interface cfla_req_if;
  logic                         valid;
  logic                         ready;
  logic                         func;
  logic [cfla_pkg::REQ_W-1:0]   request_bytes;
  logic [cfla_pkg::ADDR_W-1:0]  block_addr;

  modport source(output valid, func, request_bytes, block_addr, input ready);
  modport sink(input valid, func, request_bytes, block_addr, output ready);
endinterface

@@ rtl/core/cfla_rsp_if.sv @@
// Response channel: status and payload address, valid/ready handshake.
// Depends on cfla_pkg.
interface cfla_rsp_if;
  logic                          valid;
  logic                          ready;
  logic [cfla_pkg::STATUS_W-1:0] status;
  logic [cfla_pkg::ADDR_W-1:0]   payload_addr;

  modport source(output valid, status, payload_addr, input ready);
  modport sink(input valid, status, payload_addr, output ready);
endinterface

@@ rtl/core/cfla_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module cfla_ram #(
  parameter int W     = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [W-1:0]             wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [W-1:0]             rdata
);

  logic [W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ rtl/core/cfla_seq.sv @@
// Allocation sequencer: size rounding, next-fit walk, growth and coalescing insert.
// Depends on cfla_pkg, cfla_req_if, cfla_rsp_if; drives the two header RAMs.
module cfla_seq #(
  parameter int HEAP_UNITS = 4096,
  parameter int GROW_UNITS = 1024,
  parameter int UNIT_BYTES = 16
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                hold,
  cfla_req_if.sink                            req,
  cfla_rsp_if.source                          rsp,
  output logic [$clog2(HEAP_UNITS+2)-1:0]     sz_raddr,
  input  logic [$clog2(HEAP_UNITS+2):0]       sz_rdata,
  output logic                                sz_we,
  output logic [$clog2(HEAP_UNITS+2)-1:0]     sz_waddr,
  output logic [$clog2(HEAP_UNITS+2):0]       sz_wdata,
  output logic [$clog2(HEAP_UNITS+2)-1:0]     nx_raddr,
  input  logic [$clog2(HEAP_UNITS+2)-1:0]     nx_rdata,
  output logic                                nx_we,
  output logic [$clog2(HEAP_UNITS+2)-1:0]     nx_waddr,
  output logic [$clog2(HEAP_UNITS+2)-1:0]     nx_wdata
);
  import cfla_pkg::*;

  localparam int AW  = $clog2(HEAP_UNITS + 2);
  localparam int SW  = AW + 1;
  localparam int WW  = AW + 3;
  localparam int GW  = $clog2(GROW_UNITS + 1);
  localparam int NW  = ((DIV_W > GW) ? DIV_W : GW) + 1;
  localparam int XW  = (WW > NW) ? WW : NW;
  localparam int BW  = $clog2(UNIT_BYTES);
  localparam int DS  = DIV_W + BW;
  localparam int MW  = DIV_W + 2;
  localparam int PW  = DIV_W + MW;
  localparam int SCW = $clog2(2 * (HEAP_UNITS + 1) + 6);
  localparam logic [XW-1:0] SLOTS   = XW'(HEAP_UNITS + 1);
  localparam logic [XW-1:0] A_BOUND = XW'(2 * (HEAP_UNITS + 1) + 4);
  localparam logic [XW-1:0] I_BOUND = XW'(HEAP_UNITS + 3);
  localparam logic [XW-1:0] GROW    = XW'(GROW_UNITS);
  localparam logic [MW-1:0] RECIP   =
    MW'(((longint'(1) << DS) + longint'(UNIT_BYTES) - 1) / longint'(UNIT_BYTES));

  function automatic logic [AW-1:0] ix(input logic [XW-1:0] v);
    return (v < SLOTS) ? v[AW-1:0] : '0;
  endfunction

  state_t            state, state_next;
  caller_t           caller;
  logic [DIV_W-1:0]  dq;
  logic [NW-1:0]     nunits;
  logic [AW-1:0]     prev, p, q, rover, bpr, ip, nxr, nbp, brk;
  logic [SCW-1:0]    step, ic;
  logic [SW-1:0]     grow_nu, old_sz, szbp;
  status_t           res_status;
  logic [AW-1:0]     res_payload;
  logic              ovalid;
  logic [STATUS_W-1:0] ostatus;
  logic [ADDR_W-1:0] opayload;

  logic [PW-1:0]     quot_prod;
  logic [XW-1:0]     sz_x, n_x, nun_x, p_x, ip_x, bpr_x, brk_x, addr_x, g_nu;
  logic [SW-1:0]     newsz;
  logic              a_fit, a_exact, a_ovf, g_ovf, g_fail, i_found, i_ovf;
  logic              f_bad, mrg_hi, mrg_lo, in_ok, load;

  assign sz_x    = XW'(sz_rdata);
  assign n_x     = XW'(nx_rdata);
  assign nun_x   = XW'(nunits);
  assign p_x     = XW'(p);
  assign ip_x    = XW'(ip);
  assign bpr_x   = XW'(bpr);
  assign brk_x   = XW'(brk);
  assign addr_x  = XW'(req.block_addr);
  assign quot_prod = PW'(dq) * PW'(RECIP);
  assign a_fit   = sz_x >= nun_x;
  assign a_exact = sz_x == nun_x;
  assign newsz   = sz_rdata - SW'(nunits);
  assign a_ovf   = XW'(step) + 1'b1 > A_BOUND;
  assign g_ovf   = XW'(step) + 1'b1 > A_BOUND;
  assign g_nu    = (nun_x < GROW) ? GROW : nun_x;
  assign g_fail  = (brk_x >= SLOTS) || (g_nu > SLOTS - brk_x);
  assign i_found = (bpr_x > ip_x && bpr_x < n_x) ||
                   (ip_x >= n_x && (bpr_x > ip_x || bpr_x < n_x));
  assign i_ovf   = XW'(ic) + 1'b1 > I_BOUND;
  assign f_bad   = (sz_x == '0) || (sz_x > brk_x - bpr_x);
  assign mrg_hi  = bpr_x + XW'(szbp) == XW'(nxr);
  assign mrg_lo  = ip_x + sz_x == bpr_x;
  assign in_ok   = req.valid && req.ready;
  assign load    = (state == S_DONE) && (!ovalid || rsp.ready);

  assign req.ready        = (state == S_IDLE) && !hold;
  assign rsp.valid        = ovalid;
  assign rsp.status       = ostatus;
  assign rsp.payload_addr = opayload;

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      ovalid <= 1'b0;
      rover  <= '0;
      brk    <= AW'(1);
    end else begin
      state <= state_next;
      if (load) begin
        ovalid <= 1'b1;
      end else if (rsp.ready) begin
        ovalid <= 1'b0;
      end
      unique case (state)
        S_A_EV: begin
          if (a_fit) begin
            rover <= prev;
          end
        end
        S_I_F4: begin
          rover <= ip;
          if (caller == CALL_GROW) begin
            brk <= brk + AW'(grow_nu);
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      ostatus  <= STATUS_W'(res_status);
      opayload <= ADDR_W'(res_payload);
    end
    unique case (state)
      S_IDLE: begin
        res_payload <= '0;
        dq          <= DIV_W'(req.request_bytes) + DIV_W'(UNIT_BYTES - 1);
        step        <= '0;
        bpr         <= AW'(addr_x - 1'b1);
        if (req.func == FUNC_ALLOC) begin
          res_status <= ST_ZERO;
        end else begin
          res_status <= ST_BADFREE;
        end
      end
      S_DIV: begin
        dq <= DIV_W'(quot_prod >> DS);
      end
      S_A_NX: begin
        nunits <= NW'(dq) + 1'b1;
        prev   <= rover;
      end
      S_A_P: begin
        p <= ix(n_x);
      end
      S_A_EV: begin
        if (a_fit) begin
          res_status  <= ST_OK;
          res_payload <= p + 1'b1;
          q           <= ix(p_x + XW'(newsz));
        end else if (p == rover) begin
          res_status <= ST_NOMEM;
        end else begin
          res_status <= ST_NOMEM;
          prev       <= p;
          p          <= ix(n_x);
          step       <= step + 1'b1;
        end
      end
      S_A_SPLIT: begin
        res_payload <= q + 1'b1;
      end
      S_G_CHK: begin
        grow_nu <= SW'(g_nu);
      end
      S_G_OLD: begin
        old_sz <= sz_rdata;
        bpr    <= brk;
        caller <= CALL_GROW;
        ip     <= rover;
        ic     <= '0;
      end
      S_G_AD: begin
        prev <= rover;
        p    <= ix(n_x);
        step <= step + 1'b1;
      end
      S_F_EV: begin
        res_status <= f_bad ? ST_BADSIZE : ST_OK;
        caller     <= CALL_FREE;
        ip         <= rover;
        ic         <= '0;
      end
      S_I_EV: begin
        if (i_found) begin
          nxr <= ix(n_x);
        end else begin
          ip <= ix(n_x);
          ic <= ic + 1'b1;
          if (caller == CALL_FREE && i_ovf) begin
            res_status <= ST_BADFREE;
          end
        end
      end
      S_I_F2: begin
        szbp <= sz_rdata;
        nbp  <= ix(n_x);
      end
      S_I_F3: begin
        if (mrg_hi) begin
          szbp <= szbp + sz_rdata;
        end else begin
          nbp <= nxr;
        end
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    state_next = state;
    sz_raddr   = '0;
    nx_raddr   = '0;
    sz_we      = 1'b0;
    sz_waddr   = '0;
    sz_wdata   = '0;
    nx_we      = 1'b0;
    nx_waddr   = '0;
    nx_wdata   = '0;
    unique case (state)
      S_IDLE: begin
        if (in_ok) begin
          if (req.func == FUNC_ALLOC) begin
            state_next = (req.request_bytes == '0) ? S_DONE : S_DIV;
          end else if (addr_x < XW'(2) || addr_x > brk_x) begin
            state_next = S_DONE;
          end else begin
            state_next = S_F_RD;
          end
        end
      end
      S_DIV: begin
        state_next = S_A_NX;
      end
      S_A_NX: begin
        nx_raddr   = rover;
        state_next = S_A_P;
      end
      S_A_P: begin
        state_next = S_A_RD;
      end
      S_A_RD: begin
        sz_raddr   = p;
        nx_raddr   = p;
        state_next = S_A_EV;
      end
      S_A_EV: begin
        if (a_fit) begin
          if (a_exact) begin
            nx_we      = 1'b1;
            nx_waddr   = prev;
            nx_wdata   = nx_rdata;
            state_next = S_DONE;
          end else begin
            sz_we      = 1'b1;
            sz_waddr   = p;
            sz_wdata   = newsz;
            state_next = S_A_SPLIT;
          end
        end else if (p == rover) begin
          state_next = S_G_CHK;
        end else begin
          state_next = a_ovf ? S_DONE : S_A_RD;
        end
      end
      S_A_SPLIT: begin
        sz_we      = 1'b1;
        sz_waddr   = q;
        sz_wdata   = SW'(nunits);
        state_next = S_DONE;
      end
      S_G_CHK: begin
        sz_raddr   = brk;
        state_next = g_fail ? S_DONE : S_G_OLD;
      end
      S_G_OLD: begin
        sz_we      = 1'b1;
        sz_waddr   = brk;
        sz_wdata   = grow_nu;
        state_next = S_I_RD;
      end
      S_G_NX: begin
        nx_raddr   = rover;
        state_next = S_G_AD;
      end
      S_G_AD: begin
        state_next = g_ovf ? S_DONE : S_A_RD;
      end
      S_F_RD: begin
        sz_raddr   = bpr;
        state_next = S_F_EV;
      end
      S_F_EV: begin
        state_next = f_bad ? S_DONE : S_I_RD;
      end
      S_I_RD: begin
        nx_raddr   = ip;
        state_next = S_I_EV;
      end
      S_I_EV: begin
        if (i_found) begin
          state_next = S_I_F1;
        end else if (i_ovf) begin
          if (caller == CALL_GROW) begin
            sz_we    = 1'b1;
            sz_waddr = bpr;
            sz_wdata = old_sz;
          end
          state_next = S_DONE;
        end else begin
          state_next = S_I_RD;
        end
      end
      S_I_F1: begin
        sz_raddr   = bpr;
        nx_raddr   = nxr;
        state_next = S_I_F2;
      end
      S_I_F2: begin
        sz_raddr   = nxr;
        state_next = S_I_F3;
      end
      S_I_F3: begin
        sz_raddr = ip;
        nx_we    = 1'b1;
        nx_waddr = bpr;
        if (mrg_hi) begin
          sz_we    = 1'b1;
          sz_waddr = bpr;
          sz_wdata = szbp + sz_rdata;
          nx_wdata = nbp;
        end else begin
          nx_wdata = nxr;
        end
        state_next = S_I_F4;
      end
      S_I_F4: begin
        nx_we    = 1'b1;
        nx_waddr = ip;
        if (mrg_lo) begin
          sz_we    = 1'b1;
          sz_waddr = ip;
          sz_wdata = sz_rdata + szbp;
          nx_wdata = nbp;
        end else begin
          nx_wdata = bpr;
        end
        state_next = (caller == CALL_GROW) ? S_G_NX : S_DONE;
      end
      S_DONE: begin
        if (load) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

@@ rtl/core/coalescing_free_list_allocator_top.sv @@
// Coalescing next-fit free-list allocator: top level with header RAMs and clearing pass.
// Depends on cfla_pkg, cfla_req_if, cfla_rsp_if, cfla_ram and cfla_seq.
//
// One request is in flight at a time, with one result per request. After reset
// a clearing pass zeroes all HEAP_UNITS+1 entries of both header RAMs before
// the first request is taken. An allocate rounds its byte count to units by a
// reciprocal multiplication and fetches the rover's successor, then reads
// each free-list header visited on the next-fit walk; a growth checks the heap
// bound, writes the new block's header and inserts it, then resumes the walk.
// A free checks the header, and a free or insert walks the address-ordered
// list one header at a time and then coalesces. Each header visit is one read
// of the header RAMs, so the work grows with the length of the free list.
module coalescing_free_list_allocator_top #(
  parameter int HEAP_UNITS = 4096,
  parameter int GROW_UNITS = 1024,
  parameter int UNIT_BYTES = 16
) (
  input  logic       clk,
  input  logic       rst,
  cfla_req_if.sink   req,
  cfla_rsp_if.source rsp
);
  import cfla_pkg::*;

  localparam int AW    = $clog2(HEAP_UNITS + 2);
  localparam int SW    = AW + 1;
  localparam int SLOTS = HEAP_UNITS + 1;

  logic          clearing;
  logic [AW-1:0] clr_addr;

  logic [AW-1:0] sz_raddr, sz_waddr, s_sz_waddr;
  logic [SW-1:0] sz_rdata, sz_wdata, s_sz_wdata;
  logic          sz_we, s_sz_we;
  logic [AW-1:0] nx_raddr, nx_waddr, s_nx_waddr, nx_rdata, nx_wdata, s_nx_wdata;
  logic          nx_we, s_nx_we;

  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_addr <= '0;
    end else if (clearing) begin
      if (clr_addr == AW'(SLOTS - 1)) begin
        clearing <= 1'b0;
      end else begin
        clr_addr <= clr_addr + 1'b1;
      end
    end
  end

  assign sz_we    = clearing ? 1'b1 : s_sz_we;
  assign sz_waddr = clearing ? clr_addr : s_sz_waddr;
  assign sz_wdata = clearing ? '0 : s_sz_wdata;
  assign nx_we    = clearing ? 1'b1 : s_nx_we;
  assign nx_waddr = clearing ? clr_addr : s_nx_waddr;
  assign nx_wdata = clearing ? '0 : s_nx_wdata;

  cfla_ram #(.W(SW), .DEPTH(SLOTS)) u_size_ram (
    .clk  (clk),
    .we   (sz_we),
    .waddr(sz_waddr),
    .wdata(sz_wdata),
    .raddr(sz_raddr),
    .rdata(sz_rdata)
  );

  cfla_ram #(.W(AW), .DEPTH(SLOTS)) u_next_ram (
    .clk  (clk),
    .we   (nx_we),
    .waddr(nx_waddr),
    .wdata(nx_wdata),
    .raddr(nx_raddr),
    .rdata(nx_rdata)
  );

  cfla_seq #(
    .HEAP_UNITS(HEAP_UNITS),
    .GROW_UNITS(GROW_UNITS),
    .UNIT_BYTES(UNIT_BYTES)
  ) u_seq (
    .clk     (clk),
    .rst     (rst),
    .hold    (clearing),
    .req     (req),
    .rsp     (rsp),
    .sz_raddr(sz_raddr),
    .sz_rdata(sz_rdata),
    .sz_we   (s_sz_we),
    .sz_waddr(s_sz_waddr),
    .sz_wdata(s_sz_wdata),
    .nx_raddr(nx_raddr),
    .nx_rdata(nx_rdata),
    .nx_we   (s_nx_we),
    .nx_waddr(s_nx_waddr),
    .nx_wdata(s_nx_wdata)
  );

endmodule
